@@ sv/nearest_neighbor_image_resize_defines.svh @@
`ifndef NEAREST_NEIGHBOR_IMAGE_RESIZE_DEFINES_SVH
`define NEAREST_NEIGHBOR_IMAGE_RESIZE_DEFINES_SVH

// Check a same-cycle implication, quiet while in reset.
`define NNIR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle, quiet while in reset.
`define NNIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/nnir_pkg.sv @@
package nnir_pkg;

  localparam int MAX_DIM_DEF = 128;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;

  localparam logic [CFG_DATA_W-1:0] SIZE_RST = 8'd64;

  // Request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  localparam int PIXEL_W = 32;

  typedef struct packed {
    logic               req_type;
    logic [PIXEL_W-1:0] source_pixel;
  } in_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] out_pixel;
    logic               out_last;
  } out_t;

endpackage

@@ sv/nearest_neighbor_image_resize.sv @@
// Nearest-neighbour RGBA scaler with an on-chip frame store.
// Input channel (in_valid / in_stall / in_data): req_type selects a load, which
// writes source_pixel at the load pointer in raster order, or a fetch, which
// returns the next destination pixel in raster order. A transaction completes
// when in_valid is high and in_stall low. Loads give no result.
// Result channel (out_valid / out_stall / out_data): one transaction per fetch,
// carrying out_pixel and out_last, set on the final pixel of the output frame.
// Configuration port (cfg_valid / cfg_ready / cfg_index / cfg_wdata): the four
// size registers; cfg_ready is always high. Write only while the block is idle.
// Loads are taken back to back while no fetch is in progress. A fetch holds
// the input channel until its result is registered: the source column and row
// come from two radix-2 restoring dividers, one per axis, that each retire one
// quotient bit per cycle over NUM_W = clog2(MAX_DIM) + clog2(MAX_DIM+1) bits,
// followed by clamp, frame-store read and result registration.
// A finished result waits in the output register while out_stall is high;
// loads keep flowing meanwhile, the next fetch waits only for that register.
// Reset (rst_n, synchronous) clears the pointers, the output register and the
// sizes (64 x 64); the frame store is not cleared and must be loaded first.
module nearest_neighbor_image_resize #(
  parameter int MAX_DIM = nnir_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  nnir_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output nnir_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nnir_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nnir_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAX_DIM + 1);   // effective size
  localparam int CW    = $clog2(MAX_DIM);       // destination column / row
  localparam int NUM_W = CW + SW;               // dividend and quotient
  localparam int CNT_W = $clog2(NUM_W);
  localparam int RAW_W = nnir_pkg::CFG_DATA_W;
  localparam int EXT_W = (RAW_W > SW) ? RAW_W : SW;
  localparam int FW    = (2 * SW > AW + 1) ? 2 * SW : AW + 1;
  localparam int PW    = 2 * SW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_CLAMP = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  // Map a raw size register onto 1..MAX_DIM.
  function automatic logic [SW-1:0] eff_size(input logic [RAW_W-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    if (v == '0) begin
      ext = EXT_W'(1);
    end else if (ext > EXT_W'(MAX_DIM)) begin
      ext = EXT_W'(MAX_DIM);
    end
    return ext[SW-1:0];
  endfunction

  // Size registers
  logic [RAW_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [SW-1:0]    sw, sh, dw, dh;

  // Control state
  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    load_idx_r, load_idx_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [CW-1:0]    row_r, row_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Working registers of one fetch
  logic [NUM_W-1:0] numx_r, numx_nxt, numy_r, numy_nxt;
  logic [SW-1:0]    remx_r, remx_nxt, remy_r, remy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0]    sx_r, sy_r;
  logic             last_r, last_nxt;
  nnir_pkg::out_t   out_data_r;

  // Handshakes
  logic in_acc, ld_acc, fe_acc, out_take, out_load;

  // Load pointer arithmetic
  logic [FW-1:0]    frame, ld_inc;

  // Counter arithmetic
  logic [SW-1:0]    col_inc, row_inc;
  logic             col_wrap, row_wrap;

  // Divider step
  logic [SW:0]      trial_x, trial_y, diff_x, diff_y;
  logic             ge_x, ge_y;

  // Store access
  logic [PW-1:0]    addr_full;
  logic [AW-1:0]    rd_addr;
  logic             rd_en;
  logic [nnir_pkg::PIXEL_W-1:0] rd_data;

  assign sw = eff_size(src_w_r);
  assign sh = eff_size(src_h_r);
  assign dw = eff_size(dst_w_r);
  assign dh = eff_size(dst_h_r);

  // Configuration writes are to be made only while idle; the block itself does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= nnir_pkg::SIZE_RST;
      src_h_r <= nnir_pkg::SIZE_RST;
      dst_w_r <= nnir_pkg::SIZE_RST;
      dst_h_r <= nnir_pkg::SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nnir_pkg::CFG_SRC_WIDTH:  src_w_r <= cfg_wdata;
        nnir_pkg::CFG_SRC_HEIGHT: src_h_r <= cfg_wdata;
        nnir_pkg::CFG_DST_WIDTH:  dst_w_r <= cfg_wdata;
        nnir_pkg::CFG_DST_HEIGHT: dst_h_r <= cfg_wdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Hold the input channel for the whole of a fetch; this also keeps loads
  // from overtaking the store read of an earlier fetch.
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign ld_acc   = in_acc && (in_data.req_type == nnir_pkg::REQ_LOAD);
  assign fe_acc   = in_acc && (in_data.req_type == nnir_pkg::REQ_FETCH);

  assign out_take = out_valid_r && !out_stall;
  assign out_load = (state_r == ST_RESP) && (!out_valid_r || !out_stall);

  // Load pointer: wrap after one source frame, including the case where a
  // shrunk frame leaves the pointer beyond its new end.
  assign frame  = FW'(sw) * FW'(sh);
  assign ld_inc = FW'(load_idx_r) + FW'(1);

  always_comb begin
    load_idx_nxt = load_idx_r;
    if (ld_acc) begin
      load_idx_nxt = (ld_inc >= frame) ? '0 : ld_inc[AW-1:0];
    end
  end

  // Destination raster counters advance as soon as the fetch is taken.
  assign col_inc  = SW'(col_r) + SW'(1);
  assign row_inc  = SW'(row_r) + SW'(1);
  assign col_wrap = (col_inc >= dw);
  assign row_wrap = (row_inc >= dh);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    last_nxt = last_r;
    if (fe_acc) begin
      last_nxt = col_wrap && row_wrap;
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_inc[CW-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  // Restoring divider, one quotient bit per cycle for each axis. The dividend
  // register shifts out its top bit and takes the quotient bit at the bottom.
  assign trial_x = {remx_r, numx_r[NUM_W-1]};
  assign trial_y = {remy_r, numy_r[NUM_W-1]};
  assign ge_x    = (trial_x >= {1'b0, dw});
  assign ge_y    = (trial_y >= {1'b0, dh});
  assign diff_x  = trial_x - {1'b0, dw};
  assign diff_y  = trial_y - {1'b0, dh};

  always_comb begin
    numx_nxt = numx_r;
    numy_nxt = numy_r;
    remx_nxt = remx_r;
    remy_nxt = remy_r;
    cnt_nxt  = cnt_r;
    if (fe_acc) begin
      // Dividends x * src_width and y * src_height for the current position.
      numx_nxt = NUM_W'(NUM_W'(col_r) * NUM_W'(sw));
      numy_nxt = NUM_W'(NUM_W'(row_r) * NUM_W'(sh));
      remx_nxt = '0;
      remy_nxt = '0;
      cnt_nxt  = CNT_W'(NUM_W - 1);
    end else if (state_r == ST_DIV) begin
      numx_nxt = {numx_r[NUM_W-2:0], ge_x};
      numy_nxt = {numy_r[NUM_W-2:0], ge_y};
      remx_nxt = ge_x ? diff_x[SW-1:0] : trial_x[SW-1:0];
      remy_nxt = ge_y ? diff_y[SW-1:0] : trial_y[SW-1:0];
      cnt_nxt  = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (fe_acc) state_nxt = ST_DIV;
      ST_DIV:   if (cnt_r == '0) state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_RESP;
      ST_RESP:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      load_idx_r  <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_idx_r  <= load_idx_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    numx_r <= numx_nxt;
    numy_r <= numy_nxt;
    remx_r <= remx_nxt;
    remy_r <= remy_nxt;
    cnt_r  <= cnt_nxt;
    last_r <= last_nxt;
    // Clamp to the last source column and row.
    if (state_r == ST_CLAMP) begin
      sx_r <= (numx_r >= NUM_W'(sw)) ? sw - SW'(1) : numx_r[SW-1:0];
      sy_r <= (numy_r >= NUM_W'(sh)) ? sh - SW'(1) : numy_r[SW-1:0];
    end
    if (out_load) begin
      out_data_r.out_pixel <= rd_data;
      out_data_r.out_last  <= last_r;
    end
  end

  // Store address sy * src_width + sx; issue the read, the RAM registers the data
  // and it stays put in the RAM output until the next read.
  assign addr_full = PW'(sy_r) * PW'(sw) + PW'(sx_r);
  assign rd_addr   = addr_full[AW-1:0];
  assign rd_en     = (state_r == ST_READ);

  nnir_ram #(
    .WIDTH (nnir_pkg::PIXEL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ld_acc),
    .wr_addr (load_idx_r),
    .wr_data (in_data.source_pixel),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/nnir_ram.sv @@
module nnir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/nnir_checker.sv @@
`include "nearest_neighbor_image_resize_defines.svh"

module nnir_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input nnir_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input nnir_pkg::out_t out_data
);

  logic fetch_acc, load_acc;

  assign fetch_acc = in_valid && !in_stall && (in_data.req_type == nnir_pkg::REQ_FETCH);
  assign load_acc  = in_valid && !in_stall && (in_data.req_type == nnir_pkg::REQ_LOAD);

  // Hold a stalled result and its payload.
  `NNIR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

  // A fetch occupies the input channel until its result is registered.
  `NNIR_ASSERT_NEXT(a_fetch_busy, fetch_acc, in_stall, "input taken during a fetch")

  // A load never produces a result.
  `NNIR_ASSERT_NEXT(a_load_silent, load_acc && !out_valid, !out_valid, "result after a load")

  // A result appears only at the end of a fetch.
  `NNIR_ASSERT_SAME(a_result_origin, $rose(out_valid), $past(in_stall), "result without fetch")

endmodule

bind nearest_neighbor_image_resize nnir_checker u_nnir_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ tb/nnir_scaled_pixel_checker.sv @@
module nnir_scaled_pixel_checker #(
  parameter int MAX_DIM = nnir_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  nnir_pkg::in_t                    in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  nnir_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [nnir_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nnir_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                               mismatches,
  output int                               pending,
  output int                               frame_ends
);
  import nnir_pkg::*;

  localparam int STORE_WORDS = MAX_DIM * MAX_DIM;

  logic [PIXEL_W-1:0]    frame_mem [STORE_WORDS];
  logic [CFG_DATA_W-1:0] src_w_cfg, src_h_cfg, dst_w_cfg, dst_h_cfg;
  int unsigned           load_ptr, dst_col, dst_row;
  out_t                  scaled_q [$];
  int                    errs, ends;

  // Zero reads as one, anything above MAX_DIM saturates to MAX_DIM.
  function automatic int unsigned clip_size(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  always @(posedge clk) begin
    int unsigned sw, sh, dw, dh, sx, sy;
    out_t        want;

    if (!rst_n) begin
      src_w_cfg = SIZE_RST;
      src_h_cfg = SIZE_RST;
      dst_w_cfg = SIZE_RST;
      dst_h_cfg = SIZE_RST;
      load_ptr  = 0;
      dst_col   = 0;
      dst_row   = 0;
      errs      = 0;
      ends      = 0;
      scaled_q.delete();
    end else begin
      sw = clip_size(src_w_cfg);
      sh = clip_size(src_h_cfg);
      dw = clip_size(dst_w_cfg);
      dh = clip_size(dst_h_cfg);

      // Retire results before queueing new ones: a result never stems from
      // a fetch taken at the same edge.
      if (out_valid && !out_stall) begin
        if (scaled_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result, expected none, got pixel %h last %0b",
                   $time, out_data.out_pixel, out_data.out_last);
        end else begin
          want = scaled_q.pop_front();
          if (out_data.out_pixel !== want.out_pixel) begin
            errs++;
            $display("%0t: out_pixel expected %h, got %h",
                     $time, want.out_pixel, out_data.out_pixel);
          end
          if (out_data.out_last !== want.out_last) begin
            errs++;
            $display("%0t: out_last expected %0b, got %0b",
                     $time, want.out_last, out_data.out_last);
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (in_data.req_type == REQ_LOAD) begin
          if (load_ptr < STORE_WORDS) frame_mem[load_ptr] = in_data.source_pixel;
          if (load_ptr + 1 >= sw * sh) load_ptr = 0;
          else load_ptr++;
        end else begin
          sx = dst_col * sw / dw;
          sy = dst_row * sh / dh;
          if (sx >= sw) sx = sw - 1;
          if (sy >= sh) sy = sh - 1;
          want.out_pixel = frame_mem[sy * sw + sx];
          want.out_last  = 1'b0;
          if (dst_col + 1 >= dw) begin
            dst_col = 0;
            if (dst_row + 1 >= dh) begin
              dst_row = 0;
              want.out_last = 1'b1;
              ends++;
            end else begin
              dst_row++;
            end
          end else begin
            dst_col++;
          end
          scaled_q.push_back(want);
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SRC_WIDTH:  src_w_cfg = cfg_wdata;
          CFG_SRC_HEIGHT: src_h_cfg = cfg_wdata;
          CFG_DST_WIDTH:  dst_w_cfg = cfg_wdata;
          CFG_DST_HEIGHT: dst_h_cfg = cfg_wdata;
          default: ;
        endcase
      end
    end

    mismatches <= errs;
    pending    <= scaled_q.size();
    frame_ends <= ends;
  end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  import nnir_pkg::*;

  localparam int FILL_WORDS    = 2 * MAX_DIM_DEF;  // largest frame used below
  localparam int RANDOM_ITEMS  = 320;
  localparam int IDLE_PERCENT  = 11;
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int HOLD_FETCHES  = 12;    // fetches offered while held
  localparam int HOLD_PHASE    = 0;
  localparam int CALM_FIRST    = 1;     // phases with no idling on either side
  localparam int CALM_LAST     = 3;
  localparam int SETTLE_CYCLES = 40;    // idle time after the last result
  localparam int STALL_LIMIT   = 3000;  // cycles without any transaction
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = CFG_IDX_W'(CFG_DST_HEIGHT + 2);

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_t                   in_data   = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SRC_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_stall, out_valid, cfg_ready;
  out_t                  out_data;

  int mismatches, pending, frame_ends;
  int loads = 0, fetches = 0, settings = 0, quiet_cycles = 0;
  bit calm = 1'b0, hold_req = 1'b0, hold_done = 1'b0;

  always #10 clk = ~clk;

  nearest_neighbor_image_resize dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  nnir_scaled_pixel_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending),
    .frame_ends (frame_ends)
  );

  // Receiver: stall at random, except in calm phases; once, on request, hold
  // off for a long stretch so the output register fills and the input backs up.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Watchdog: end the run if no transaction of any kind moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d cycles without a transaction", quiet_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request, with random idle cycles ahead of it, and hold it until
  // the block takes it. Leave valid high: the caller lowers it when done.
  task automatic push_item(input logic kind, input logic [PIXEL_W-1:0] pix);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {kind, pix};
    do @(posedge clk); while (in_stall);
    if (kind == REQ_LOAD) loads++;
    else fetches++;
  endtask

  // Leave cfg_valid high so back-to-back writes need no second assignment
  // in one step; set_sizes drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_sizes(input logic [CFG_DATA_W-1:0] sw, sh, dw, dh);
    // Now and then slip in a write to an index outside the register list.
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(CFG_DST_HEIGHT + 1, (1 << CFG_IDX_W) - 1)),
                CFG_DATA_W'($urandom()));
    write_reg(CFG_SRC_WIDTH, sw);
    write_reg(CFG_SRC_HEIGHT, sh);
    write_reg(CFG_DST_WIDTH, dw);
    write_reg(CFG_DST_HEIGHT, dh);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Drop valid, wait for every outstanding fetch to return, then let the
  // fetch pipeline run dry before anything else happens.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly small frames; now and then one side at the maximum with the other
  // kept tiny so the run stays short.
  task automatic pick_dims(output int unsigned w, output int unsigned h);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) begin
      w = MAX_DIM_DEF;
      h = $urandom_range(1, 2);
    end else if (roll < 16) begin
      w = $urandom_range(1, 2);
      h = MAX_DIM_DEF;
    end else if (roll < 22) begin
      w = 1;
      h = 1;
    end else begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 6);
    end
  endtask

  // Encode a size, sometimes as zero (reads as one) or as an over-range value
  // (saturates to the maximum).
  function automatic logic [CFG_DATA_W-1:0] raw_size(input int unsigned eff);
    if (eff == 1 && $urandom_range(3) == 0) return '0;
    if (eff == MAX_DIM_DEF && $urandom_range(1) == 0)
      return CFG_DATA_W'($urandom_range(MAX_DIM_DEF + 1, (1 << CFG_DATA_W) - 1));
    return CFG_DATA_W'(eff);
  endfunction

  initial begin
    int unsigned sw, sh, dw, dh;
    int          phase, base;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Fill every store entry that any later frame can address (the largest
    // frame below is MAX_DIM x 2), so no fetch lands on an unwritten entry.
    set_sizes(CFG_DATA_W'(MAX_DIM_DEF), 8'd2, SIZE_RST, SIZE_RST);
    repeat (FILL_WORDS) push_item(REQ_LOAD, $urandom());
    settle();

    // One-pixel frames with all-ones and all-zero pixels; every fetch is last.
    set_sizes(8'd1, 8'd1, 8'd1, 8'd1);
    push_item(REQ_LOAD, '1);
    push_item(REQ_FETCH, '0);
    push_item(REQ_LOAD, '0);
    push_item(REQ_FETCH, '1);
    settle();

    // Strong horizontal downscale from a full-width source.
    set_sizes(CFG_DATA_W'(MAX_DIM_DEF), 8'd2, 8'd3, 8'd2);
    repeat (6) push_item(REQ_FETCH, $urandom());
    settle();

    // Zero and over-range sizes plus a write to an unused index; stop the
    // destination frame halfway.
    write_reg(CFG_UNUSED_IDX, 8'hA5);
    set_sizes(8'd0, 8'd200, 8'd2, 8'd3);
    repeat (2) push_item(REQ_LOAD, $urandom());
    repeat (3) push_item(REQ_FETCH, $urandom());
    settle();

    // Shrink every size mid-frame: the load pointer and the output cursor now
    // sit past the frame, so both must clamp and wrap.
    set_sizes(8'd1, 8'd1, 8'd1, 8'd1);
    push_item(REQ_LOAD, $urandom());
    repeat (2) push_item(REQ_FETCH, $urandom());
    settle();

    // Random phases: new sizes, then mostly a whole source frame followed by
    // a whole destination frame with a little noise, otherwise a random mix.
    // Calm phases always run whole frames.
    base  = loads + fetches;
    phase = 0;
    while (phase <= CALM_LAST || loads + fetches - base < RANDOM_ITEMS) begin
      calm = (phase >= CALM_FIRST && phase <= CALM_LAST);
      pick_dims(sw, sh);
      pick_dims(dw, dh);
      set_sizes(raw_size(sw), raw_size(sh), raw_size(dw), raw_size(dh));
      if (phase == HOLD_PHASE) begin
        hold_req = 1'b1;
        repeat (HOLD_FETCHES) push_item(REQ_FETCH, $urandom());
      end
      if (calm || $urandom_range(99) < 75) begin
        repeat (sw * sh) begin
          if ($urandom_range(99) < 5) push_item(REQ_FETCH, $urandom());
          push_item(REQ_LOAD, $urandom());
        end
        repeat (dw * dh) begin
          if ($urandom_range(99) < 5) push_item(REQ_LOAD, $urandom());
          push_item(REQ_FETCH, $urandom());
        end
      end else begin
        repeat ($urandom_range(1, 20)) push_item(1'($urandom_range(1)), $urandom());
      end
      settle();
      phase++;
    end
    calm = 1'b0;

    $display("Run covered %0d loads and %0d fetches over %0d size settings,",
             loads, fetches, settings);
    $display("completing %0d destination frames.", frame_ends);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ nearest_neighbor_image_resize.f @@
+incdir+sv
sv/nnir_pkg.sv
sv/nnir_ram.sv
sv/nearest_neighbor_image_resize.sv
sv/nnir_checker.sv
tb/nnir_scaled_pixel_checker.sv
tb/tb_top.sv
